[sv/ymdf_pkg.sv]
package ymdf_pkg;

   localparam int unsigned DEF_SHORT_PAYLOAD  = 128;
   localparam int unsigned DEF_LONG_PAYLOAD   = 1024;
   localparam int unsigned DEF_OVERHEAD_BYTES = 5;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned INDEX_W  = 11;
   localparam int unsigned LENGTH_W = 11;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned NUM_REGS = 6;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned RSP_DATA_W = 32;

   localparam logic [BYTE_W-1:0] INV_MASK = 8'hff;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SHORT_START = 3'd0,
      REG_LONG_START  = 3'd1,
      REG_END         = 3'd2,
      REG_CANCEL      = 3'd3,
      REG_ABORT_UPPER = 3'd4,
      REG_ABORT_LOWER = 3'd5
   } reg_index_type;

   typedef logic [BYTE_W-1:0] reg_bank_type [NUM_REGS];

   localparam reg_bank_type REG_RESET = '{8'd1, 8'd2, 8'd4, 8'd24, 8'd65, 8'd97};

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_CANCEL = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_MISMATCH = 3'd1,
      ST_EOT      = 3'd2,
      ST_CANCEL   = 3'd3,
      ST_ABORT    = 3'd4,
      ST_ERROR    = 3'd5
   } status_type;

endpackage

[sv/ymodem_packet_deframer.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: rx_byte[7:0]; tuser: timed_out
// rsp       out        rsp_tvalid/rsp_tready  tdata: data_byte[7:0], byte_index[18:8],
//                                             pkt_len[29:19]; tuser: status;
//                                             tlast: done_res
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// Each request is decoded in the cycle it is accepted, and its response appears in the
// response register on the next cycle, so one request per cycle is sustained while unstalled.
// The response register is the only stall point: a request is taken whenever it is
// empty or being drained in the same cycle, and a lone cancel byte yields no response.
// Reset is synchronous and active high; it returns the control codes to their defaults,
// the receiver to the idle phase and empties the response register. The configuration
// port is always ready; the user must write it only while idle, which nothing enforces.
module ymodem_packet_deframer
   import ymdf_pkg::*;
#(
   parameter int unsigned SHORT_PAYLOAD  = DEF_SHORT_PAYLOAD,
   parameter int unsigned LONG_PAYLOAD   = DEF_LONG_PAYLOAD,
   parameter int unsigned OVERHEAD_BYTES = DEF_OVERHEAD_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // rx_byte
   input  logic                  req_tuser,   // timed_out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // data_byte, byte_index, pkt_len, zeros
   output logic [STATUS_W-1:0]   rsp_tuser,   // status
   output logic                  rsp_tlast,   // done_res
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0]     csr_data
);

   localparam logic [LENGTH_W-1:0] SHORT_LEN  = LENGTH_W'(SHORT_PAYLOAD);
   localparam logic [LENGTH_W-1:0] LONG_LEN   = LENGTH_W'(LONG_PAYLOAD);
   localparam logic [INDEX_W-1:0]  SHORT_LAST = INDEX_W'(SHORT_PAYLOAD + OVERHEAD_BYTES - 1);
   localparam logic [INDEX_W-1:0]  LONG_LAST  = INDEX_W'(LONG_PAYLOAD + OVERHEAD_BYTES - 1);

   reg_bank_type           regs_ff;
   phase_type              phase_ff, phase_in;
   logic                   long_ff, long_in;
   logic [INDEX_W-1:0]     count_ff, count_in;
   logic [BYTE_W-1:0]      seq_ff, seq_in;

   logic                   rsp_valid_ff;
   logic [BYTE_W-1:0]      data_ff, data_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic                   done_ff, done_in;
   status_type             status_ff, status_in;
   logic [LENGTH_W-1:0]    length_ff, length_in;

   logic                   req_accept;
   logic                   emit;
   logic                   timed_out;
   logic [BYTE_W-1:0]      rx_byte;
   logic [INDEX_W-1:0]     last_idx;
   logic [LENGTH_W-1:0]    payload_len;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rx_byte    = req_tdata;
   assign timed_out  = req_tuser;
   assign last_idx    = long_ff ? LONG_LAST : SHORT_LAST;
   assign payload_len = long_ff ? LONG_LEN : SHORT_LEN;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= REG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SHORT_START: regs_ff[REG_SHORT_START] <= csr_data;
            REG_LONG_START:  regs_ff[REG_LONG_START]  <= csr_data;
            REG_END:         regs_ff[REG_END]         <= csr_data;
            REG_CANCEL:      regs_ff[REG_CANCEL]      <= csr_data;
            REG_ABORT_UPPER: regs_ff[REG_ABORT_UPPER] <= csr_data;
            REG_ABORT_LOWER: regs_ff[REG_ABORT_LOWER] <= csr_data;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         long_ff  <= 1'b0;
         count_ff <= '0;
         seq_ff   <= '0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         long_ff  <= long_in;
         count_ff <= count_in;
         seq_ff   <= seq_in;
      end
   end

   always_comb begin
      phase_in  = PH_IDLE;
      long_in   = long_ff;
      count_in  = count_ff;
      seq_in    = seq_ff;
      emit      = 1'b1;
      data_in   = '0;
      index_in  = '0;
      done_in   = 1'b1;
      status_in = ST_ERROR;
      length_in = '0;
      case (phase_ff)
         PH_BODY: begin
            if (timed_out) begin
               count_in = '0;
            end else begin
               if (count_ff == INDEX_W'(1)) begin
                  seq_in = rx_byte;
               end else if (count_ff == INDEX_W'(2)) begin
                  seq_in = seq_ff ^ rx_byte ^ INV_MASK;
               end
               data_in  = rx_byte;
               index_in = count_ff;
               if (count_ff >= last_idx) begin
                  count_in = '0;
                  if (seq_in != '0) begin
                     status_in = ST_MISMATCH;
                  end else begin
                     status_in = ST_OK;
                     length_in = payload_len;
                  end
               end else begin
                  phase_in  = PH_BODY;
                  count_in  = count_ff + INDEX_W'(1);
                  done_in   = 1'b0;
                  status_in = ST_OK;
               end
            end
         end
         PH_CANCEL: begin
            if (!timed_out && rx_byte == regs_ff[REG_CANCEL]) begin
               status_in = ST_CANCEL;
            end
         end
         default: begin
            if (timed_out) begin
               status_in = ST_ERROR;
            end else if (rx_byte == regs_ff[REG_SHORT_START]
                         || rx_byte == regs_ff[REG_LONG_START]) begin
               long_in   = (rx_byte != regs_ff[REG_SHORT_START]);
               count_in  = INDEX_W'(1);
               seq_in    = '0;
               phase_in  = PH_BODY;
               data_in   = rx_byte;
               done_in   = 1'b0;
               status_in = ST_OK;
            end else if (rx_byte == regs_ff[REG_END]) begin
               status_in = ST_EOT;
            end else if (rx_byte == regs_ff[REG_CANCEL]) begin
               phase_in = PH_CANCEL;
               emit     = 1'b0;
            end else if (rx_byte == regs_ff[REG_ABORT_UPPER]
                         || rx_byte == regs_ff[REG_ABORT_LOWER]) begin
               status_in = ST_ABORT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         data_ff   <= data_in;
         index_ff  <= index_in;
         done_ff   <= done_in;
         status_ff <= status_in;
         length_ff <= length_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - BYTE_W - INDEX_W - LENGTH_W){1'b0}},
                        length_ff, index_ff, data_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = done_ff;

   a_body_count_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> count_ff != '0 && count_ff <= last_idx)
      else $error("body count out of range while in a packet");

   a_partial_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !done_ff |-> status_ff == ST_OK && length_ff == '0)
      else $error("unfinished response carries a final status");

   a_good_end_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff && status_ff == ST_OK |->
         length_ff == SHORT_LEN || length_ff == LONG_LEN)
      else $error("good packet end without payload length");

   a_header_opens: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_IDLE && !timed_out
         && (rx_byte == regs_ff[REG_SHORT_START] || rx_byte == regs_ff[REG_LONG_START])
      |=> phase_ff == PH_BODY && count_ff == INDEX_W'(1))
      else $error("start code did not open a packet");

   a_cancel_silent: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_CANCEL |=> phase_ff == PH_IDLE && rsp_valid_ff && done_ff)
      else $error("second cancel byte did not close the event");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench
   import ymdf_pkg::*;
();

   localparam reg_bank_type EXTREME_CODES = '{8'h00, 8'hff, 8'h01, 8'hfe, 8'h80, 8'h7f};
   localparam reg_bank_type SHARED_CODES  = '{8'h11, 8'h22, 8'h22, 8'h33, 8'h33, 8'h33};
   localparam int unsigned PHASE_ITEMS = 4;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [BYTE_W-1:0]   data_byte;
      logic [INDEX_W-1:0]  byte_index;
      logic                done;
      status_type          status;
      logic [LENGTH_W-1:0] pkt_len;
   } frame_result_type;

   class deframe_scoreboard_type;
      reg_bank_type        codes;
      phase_type           phase;
      bit                  long_pkt;
      int unsigned         body_count;
      logic [BYTE_W-1:0]   seq_acc;
      frame_result_type    pending[$];
      int unsigned         errors;

      function new();
         codes = REG_RESET;
         phase = PH_IDLE;
         long_pkt = 1'b0;
         body_count = 0;
         seq_acc = '0;
         errors = 0;
      endfunction

      function void write_code(logic [CSR_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
         if (idx < NUM_REGS) begin
            codes[idx] = value;
         end
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b, logic tmo);
         frame_result_type r;
         int unsigned payload;
         int unsigned last;
         r = '0;
         r.done = 1'b1;
         r.status = ST_ERROR;
         case (phase)
            PH_BODY: begin
               payload = long_pkt ? DEF_LONG_PAYLOAD : DEF_SHORT_PAYLOAD;
               last = payload + DEF_OVERHEAD_BYTES - 1;
               if (tmo) begin
                  phase = PH_IDLE;
                  body_count = 0;
               end else begin
                  if (body_count == 1) begin
                     seq_acc = b;
                  end else if (body_count == 2) begin
                     seq_acc = seq_acc ^ b ^ INV_MASK;
                  end
                  r.data_byte = b;
                  r.byte_index = INDEX_W'(body_count);
                  if (body_count >= last) begin
                     phase = PH_IDLE;
                     body_count = 0;
                     if (seq_acc != '0) begin
                        r.status = ST_MISMATCH;
                     end else begin
                        r.status = ST_OK;
                        r.pkt_len = LENGTH_W'(payload);
                     end
                  end else begin
                     body_count++;
                     r.done = 1'b0;
                     r.status = ST_OK;
                  end
               end
            end
            PH_CANCEL: begin
               phase = PH_IDLE;
               r.status = (!tmo && b == codes[REG_CANCEL]) ? ST_CANCEL : ST_ERROR;
            end
            default: begin
               phase = PH_IDLE;
               if (tmo) begin
                  r.status = ST_ERROR;
               end else if (b == codes[REG_SHORT_START] || b == codes[REG_LONG_START]) begin
                  long_pkt = (b != codes[REG_SHORT_START]);
                  body_count = 1;
                  seq_acc = '0;
                  phase = PH_BODY;
                  r.data_byte = b;
                  r.done = 1'b0;
                  r.status = ST_OK;
               end else if (b == codes[REG_END]) begin
                  r.status = ST_EOT;
               end else if (b == codes[REG_CANCEL]) begin
                  phase = PH_CANCEL;
                  return;
               end else if (b == codes[REG_ABORT_UPPER] || b == codes[REG_ABORT_LOWER]) begin
                  r.status = ST_ABORT;
               end
            end
         endcase
         pending.push_back(r);
      endfunction

      function void flag(string what, frame_result_type want, frame_result_type got);
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("%s: expected data %h index %0d last %b status %0d length %0d,",
                     what, want.data_byte, want.byte_index, want.done, want.status,
                     want.pkt_len);
            $display("   got data %h index %0d last %b status %0d length %0d",
                     got.data_byte, got.byte_index, got.done, got.status, got.pkt_len);
         end
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         if (pending.size() == 0) begin
            flag("response with no request pending", '0, got);
            return;
         end
         want = pending.pop_front();
         if (got.data_byte !== want.data_byte || got.byte_index !== want.byte_index ||
             got.done !== want.done || got.status !== want.status ||
             got.pkt_len !== want.pkt_len) begin
            flag("response mismatch", want, got);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [BYTE_W-1:0]     csr_data = '0;

   deframe_scoreboard_type sb = new();
   bit                req_gaps = 1'b1;
   bit                rsp_stalls = 1'b1;
   int unsigned       items_sent = 0;

   ymodem_packet_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rsp_stalls || ($urandom_range(99) >= 21);
      end
   end

   // Handshakes are sampled mid-cycle, where every signal is settled for the next edge.
   always @(negedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sb.note_byte(req_tdata, req_tuser);
      end
      if (!reset && csr_valid && csr_ready) begin
         sb.write_code(csr_index, csr_data);
      end
   end

   always @(negedge clock) begin : rsp_monitor
      frame_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.data_byte = rsp_tdata[BYTE_W-1:0];
         got.byte_index = rsp_tdata[BYTE_W +: INDEX_W];
         got.pkt_len = rsp_tdata[BYTE_W+INDEX_W +: LENGTH_W];
         got.done = rsp_tlast;
         got.status = status_type'(rsp_tuser);
         sb.check_result(got);
      end
   end

   task automatic put_byte(input logic [BYTE_W-1:0] b, input logic tmo);
      while (req_gaps && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= tmo;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic settle();
      if (sb.phase != PH_IDLE) begin
         put_byte(BYTE_W'($urandom_range(255)), 1'b1);
      end
      drain_results();
   endtask

   task automatic program_codes(input reg_bank_type v);
      int unsigned i;
      for (i = 0; i < NUM_REGS + 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data <= (i < NUM_REGS) ? v[i] : BYTE_W'($urandom_range(255));
         do @(negedge clock); while (!csr_ready);
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // A nonzero cut_at replaces the body byte at that index with a timeout.
   task automatic send_packet(input logic [BYTE_W-1:0] header, input int unsigned payload,
                              input bit bad_seq, input int unsigned cut_at);
      logic [BYTE_W-1:0] seq;
      int unsigned total;
      int unsigned i;
      seq = BYTE_W'($urandom_range(255));
      total = payload + DEF_OVERHEAD_BYTES - 1;
      put_byte(header, 1'b0);
      for (i = 1; i <= total; i++) begin
         if (i == cut_at) begin
            put_byte(BYTE_W'($urandom_range(255)), 1'b1);
            return;
         end
         if (i == 1) begin
            put_byte(seq, 1'b0);
         end else if (i == 2) begin
            put_byte(bad_seq ? (seq ^ INV_MASK ^ BYTE_W'($urandom_range(255, 1)))
                             : (seq ^ INV_MASK), 1'b0);
         end else begin
            put_byte(BYTE_W'($urandom_range(255)), 1'b0);
         end
      end
   endtask

   function automatic reg_bank_type distinct_codes();
      reg_bank_type v;
      int unsigned i;
      int unsigned j;
      bit clash;
      for (i = 0; i < NUM_REGS; i++) begin
         do begin
            v[i] = BYTE_W'($urandom_range(255));
            clash = 1'b0;
            for (j = 0; j < i; j++) begin
               if (v[j] == v[i]) begin
                  clash = 1'b1;
               end
            end
         end while (clash);
      end
      return v;
   endfunction

   task automatic send_random_sequence();
      int unsigned pick;
      bit alt;
      if (sb.phase == PH_BODY) begin
         put_byte(BYTE_W'($urandom_range(255)), 1'b1);
      end
      pick = $urandom_range(99);
      alt = ($urandom_range(3) == 0);
      if (pick < 30) begin
         send_packet(sb.codes[REG_SHORT_START], DEF_SHORT_PAYLOAD,
                     $urandom_range(5) == 0, 0);
      end else if (pick < 45) begin
         if (alt) begin
            send_packet(sb.codes[REG_LONG_START], DEF_LONG_PAYLOAD,
                        $urandom_range(1), $urandom_range(40, 1));
         end else begin
            send_packet(sb.codes[REG_SHORT_START], DEF_SHORT_PAYLOAD, $urandom_range(1),
                        $urandom_range(DEF_SHORT_PAYLOAD + DEF_OVERHEAD_BYTES - 1, 1));
         end
      end else if (pick < 55) begin
         put_byte(sb.codes[REG_END], 1'b0);
      end else if (pick < 65) begin
         put_byte(sb.codes[REG_CANCEL], 1'b0);
         put_byte(sb.codes[REG_CANCEL], 1'b0);
      end else if (pick < 74) begin
         put_byte(alt ? sb.codes[REG_ABORT_UPPER] : sb.codes[REG_ABORT_LOWER], 1'b0);
      end else if (pick < 82) begin
         put_byte(sb.codes[REG_CANCEL], 1'b0);
         put_byte(BYTE_W'($urandom_range(255)), alt);
      end else if (pick < 88) begin
         put_byte(BYTE_W'($urandom_range(255)), 1'b1);
      end else if (pick < 97) begin
         put_byte(BYTE_W'($urandom_range(255)), 1'b0);
      end else begin
         drain_results();
      end
   endtask

   initial begin
      #1_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reg_bank_type codes;
      int unsigned p;
      int unsigned target;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      put_byte(8'h00, 1'b1);
      put_byte(sb.codes[REG_END], 1'b0);
      put_byte(sb.codes[REG_CANCEL], 1'b0);
      put_byte(sb.codes[REG_CANCEL], 1'b0);
      put_byte(sb.codes[REG_CANCEL], 1'b0);
      put_byte(8'hff, 1'b1);
      put_byte(sb.codes[REG_CANCEL], 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(sb.codes[REG_ABORT_UPPER], 1'b0);
      put_byte(sb.codes[REG_ABORT_LOWER], 1'b0);
      put_byte(8'hff, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(sb.codes[REG_SHORT_START], 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'hff, 1'b0);
      put_byte(8'h00, 1'b1);
      put_byte(sb.codes[REG_LONG_START], 1'b0);
      put_byte(8'hff, 1'b1);
      put_byte(8'hff, 1'b1);
      drain_results();

      // With every code equal, the short start wins.
      codes = '{default: 8'h00};
      program_codes(codes);
      put_byte(8'h00, 1'b0);
      put_byte(8'h00, 1'b1);
      drain_results();

      // Long start beats end, and cancel beats both abort codes.
      program_codes(SHARED_CODES);
      put_byte(sb.codes[REG_LONG_START], 1'b0);
      put_byte(8'h00, 1'b1);
      put_byte(sb.codes[REG_CANCEL], 1'b0);
      put_byte(sb.codes[REG_CANCEL], 1'b0);
      drain_results();

      program_codes(EXTREME_CODES);
      req_gaps = 1'b0;
      rsp_stalls = 1'b0;
      send_packet(sb.codes[REG_LONG_START], DEF_LONG_PAYLOAD, 1'b0, 0);
      send_packet(sb.codes[REG_SHORT_START], DEF_SHORT_PAYLOAD, 1'b0, 0);
      req_gaps = 1'b1;
      rsp_stalls = 1'b1;

      for (p = 0; p < 4; p++) begin
         case (p)
            0: codes = REG_RESET;
            2: codes = EXTREME_CODES;
            default: codes = distinct_codes();
         endcase
         settle();
         program_codes(codes);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            send_random_sequence();
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[ymodem_packet_deframer.f]
sv/ymdf_pkg.sv
sv/ymodem_packet_deframer.sv
verif/testbench.sv
